FILE: src/bitmap_block_allocator_assert.svh
// Assertion macros for the bitmap block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_HOLDS(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error(MSG);

// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
	LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error(MSG);

`endif

FILE: src/bba_pkg.sv
// Shared constants and types for the bitmap block allocator.
package bba_pkg;

	localparam int MAX_BLOCKS_DEF = 256;

	localparam int LEN_W  = 12;            // byte lengths and block counts
	localparam int BS_W   = 11;            // block_size register
	localparam int BIU_W  = 9;             // blocks_in_use register
	localparam int SB_W   = 8;             // start_block field
	localparam int EXT_W  = 13;            // block + count sums
	localparam int IDX_W  = 12;            // run start, up to the largest map
	localparam int PROD_W = LEN_W + BS_W;  // block count times block size
	localparam int BI_W   = 8;
	localparam int OFF_W  = 18;
	localparam int SAT_W  = 9;
	localparam int CFG_W  = 11;

	localparam logic [SAT_W-1:0] SAT_MAX = '1;

	localparam logic [BS_W-1:0]  BS_RESET  = 11'd16;
	localparam logic [BIU_W-1:0] BIU_RESET = 9'd256;

	localparam logic CFG_BLOCK_SIZE    = 1'b0;
	localparam logic CFG_BLOCKS_IN_USE = 1'b1;

	localparam logic [2:0] KIND_ALLOC  = 3'd0;
	localparam logic [2:0] KIND_SHRINK = 3'd1;
	localparam logic [2:0] KIND_QUERY  = 3'd2;
	localparam logic [2:0] KIND_CBEGIN = 3'd3;
	localparam logic [2:0] KIND_PLACE  = 3'd4;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FRAG     = 3'd1,
		ST_FULL     = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_OVERFLOW = 3'd4,
		ST_ZERO     = 3'd5
	} status_t;

endpackage

FILE: src/bitmap_block_allocator.sv
// Bitmap block allocator: first-fit allocation over a one-bit occupancy memory.
//
// Input channel (in_valid/in_ready) carries one request transaction: kind,
// value_length, reserved_length, start_block. Output channel (out_valid/out_ready)
// returns exactly one result transaction per request, in order.
// Requests are handled one at a time; in_ready is high only while idle.
// Steps per request, with n = min(blocks_in_use, MAX_BLOCKS):
//   allocate      divider, map scan over n, mark sweep of the run
//   shrink        two 12-step divisions, clear/count sweep over n
//   place         divider, mark/count sweep; query and other kinds count sweep
//   compact begin full clear sweep over all MAX_BLOCKS entries
// The sweep pace is set by the map memory port: one entry read (and written) per
// cycle. Lengths go through a 12-step shift-subtract divider.
// Reset: a clearing sweep over the whole map runs first; in_ready stays low
// until it ends. Configuration writes are taken at any time.
// Output is registered: a finished result waits in the output register while
// out_ready is low, and the next request is accepted meanwhile; its result
// is held internally until the register frees up.
module bitmap_block_allocator #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bba_pkg::CFG_W-1:0] cfg_data,
	// request channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                kind,
	input  logic [bba_pkg::LEN_W-1:0] value_length,
	input  logic [bba_pkg::LEN_W-1:0] reserved_length,
	input  logic [bba_pkg::SB_W-1:0]  start_block,
	// result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                status,
	output logic [bba_pkg::BI_W-1:0]  block_index,
	output logic [bba_pkg::OFF_W-1:0] byte_offset,
	output logic [bba_pkg::SAT_W-1:0] blocks_needed,
	output logic [bba_pkg::SAT_W-1:0] occupied_count
);

	`include "bitmap_block_allocator_assert.svh"

	localparam int AW    = $clog2(MAX_BLOCKS);
	localparam int CW    = $clog2(MAX_BLOCKS + 1);
	localparam int LEN_W = bba_pkg::LEN_W;
	localparam int BS_W  = bba_pkg::BS_W;
	localparam int EXT_W = bba_pkg::EXT_W;
	localparam int IDX_W = bba_pkg::IDX_W;
	localparam int PROD_W = bba_pkg::PROD_W;
	localparam int SAT_W = bba_pkg::SAT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,     // shift-subtract divider, one quotient bit per cycle
		S_PROD,    // register reserved capacity (shrink check)
		S_DECIDE,  // pick status and set up the sweep
		S_SCAN,    // first-fit search over the map
		S_SWEEP,   // read-modify-write pass: mark or clear region, count used
		S_MUL,     // byte offset
		S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [BS_W-1:0]          block_size_q;
	logic [bba_pkg::BIU_W-1:0] blocks_in_use_q;

	// latched request
	logic [2:0]               kind_q;
	logic [LEN_W-1:0]         vlen_q;
	logic [LEN_W-1:0]         rlen_q;
	logic [bba_pkg::SB_W-1:0] sblk_q;

	// divider
	logic [LEN_W-1:0] div_num_q;
	logic [BS_W-1:0]  div_rem_q;
	logic [LEN_W-1:0] div_quo_q;
	logic [3:0]       div_cnt_q;
	logic             div_sel_q;

	logic [LEN_W-1:0]  needed_q;
	logic [LEN_W-1:0]  orig_q;
	logic [PROD_W-1:0] prod_q;

	// sweep / scan control
	logic [CW-1:0]    sw_i_q;
	logic [CW-1:0]    sw_end_q;
	logic [EXT_W-1:0] lo_q;
	logic [EXT_W-1:0] hi_q;
	logic             wval_q;
	logic             init_q;
	logic             rd_v_s1;
	logic             reg_s1;
	logic [CW-1:0]    i_s1;
	logic             rd_data_s1;

	logic [CW-1:0]        run_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        pp_q;
	logic                 placed_q;
	logic [IDX_W-1:0]     idx_q;
	bba_pkg::status_t     status_q;

	// output register
	logic                      out_valid_q;
	bba_pkg::status_t          res_status_q;
	logic [bba_pkg::BI_W-1:0]  res_index_q;
	logic [bba_pkg::OFF_W-1:0] res_offset_q;
	logic [SAT_W-1:0]          res_needed_q;
	logic [SAT_W-1:0]          res_occ_q;

	// occupancy memory, one bit per block
	logic mem_q [MAX_BLOCKS];

	logic [CW-1:0]     n_blk;
	logic [BS_W-1:0]   bs;
	logic              issue;
	logic [EXT_W-1:0]  sw_ext;
	logic              in_region;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [LEN_W-1:0]  div_shift;
	logic              div_ge;
	logic [BS_W-1:0]   div_rem_n;
	logic [LEN_W-1:0]  div_quo_n;
	logic [LEN_W-1:0]  div_res;
	logic [LEN_W-1:0]  mul_a;
	logic [PROD_W-1:0] mul_p;
	logic [EXT_W-1:0]  run_inc;
	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	logic              vlen_zero;
	logic [EXT_W-1:0]  pp_end;
	logic              frag;

	// managed blocks and effective block size (zero acts as one)
	assign n_blk = (EXT_W'(blocks_in_use_q) < EXT_W'(MAX_BLOCKS)) ?
		CW'(blocks_in_use_q) : CW'(MAX_BLOCKS);
	assign bs = (block_size_q == '0) ? BS_W'(1) : block_size_q;

	assign issue = (state_q == S_SCAN || state_q == S_SWEEP) && (sw_i_q < sw_end_q);
	assign sw_ext = EXT_W'(sw_i_q);
	assign in_region = (sw_ext >= lo_q) && (sw_ext < hi_q);
	assign mem_we = issue && (state_q == S_SWEEP) && in_region;
	assign mem_addr = sw_i_q[AW-1:0];

	// ceil(num / bs): quotient plus one when a remainder is left
	assign div_shift = {div_rem_q, div_num_q[LEN_W-1]};
	assign div_ge = div_shift >= {1'b0, bs};
	assign div_rem_n = div_ge ? BS_W'(div_shift - {1'b0, bs}) : div_shift[BS_W-1:0];
	assign div_quo_n = {div_quo_q[LEN_W-2:0], div_ge};
	assign div_res = div_quo_n + LEN_W'(div_rem_n != '0);

	assign mul_a = (state_q == S_PROD) ? orig_q : idx_q;
	assign mul_p = PROD_W'(mul_a) * PROD_W'(bs);

	// first-fit tracking on the registered read data
	assign run_inc = EXT_W'(run_q) + EXT_W'(1);
	assign hit = !rd_data_s1 && !placed_q && (run_inc == EXT_W'(needed_q));
	assign hit_idx = IDX_W'(EXT_W'(i_s1) + EXT_W'(1) - EXT_W'(needed_q));

	assign vlen_zero = (vlen_q == '0);
	assign pp_end = EXT_W'(pp_q) + EXT_W'(needed_q);
	assign frag = (EXT_W'(n_blk) - EXT_W'(cnt_q)) >= EXT_W'(needed_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= wval_q;
		end
		rd_data_s1 <= mem_q[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_SWEEP;
			init_q          <= 1'b1;
			sw_i_q          <= '0;
			sw_end_q        <= CW'(MAX_BLOCKS);
			lo_q            <= '0;
			hi_q            <= EXT_W'(MAX_BLOCKS);
			wval_q          <= 1'b0;
			rd_v_s1         <= 1'b0;
			cnt_q           <= '0;
			pp_q            <= '0;
			placed_q        <= 1'b0;
			div_cnt_q       <= '0;
			div_sel_q       <= 1'b0;
			out_valid_q     <= 1'b0;
			block_size_q    <= bba_pkg::BS_RESET;
			blocks_in_use_q <= bba_pkg::BIU_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bba_pkg::CFG_BLOCK_SIZE:    block_size_q <= cfg_data[BS_W-1:0];
					bba_pkg::CFG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_data[bba_pkg::BIU_W-1:0];
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			rd_v_s1 <= issue;
			reg_s1  <= in_region;
			i_s1    <= sw_i_q;
			if (issue) begin
				sw_i_q <= sw_i_q + CW'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q   <= kind;
						vlen_q   <= value_length;
						rlen_q   <= reserved_length;
						sblk_q   <= start_block;
						needed_q <= '0;
						orig_q   <= '0;
						placed_q <= 1'b0;
						idx_q    <= '0;
						status_q <= bba_pkg::ST_OK;
						if (kind == bba_pkg::KIND_ALLOC || kind == bba_pkg::KIND_SHRINK ||
						    kind == bba_pkg::KIND_PLACE) begin
							div_num_q <= value_length;
							div_rem_q <= '0;
							div_quo_q <= '0;
							div_cnt_q <= 4'(LEN_W);
							div_sel_q <= 1'b0;
							state_q   <= S_DIV;
						end else begin
							state_q <= S_PROD;
						end
					end
				end

				S_DIV: begin
					div_num_q <= div_num_q << 1;
					div_rem_q <= div_rem_n;
					div_quo_q <= div_quo_n;
					div_cnt_q <= div_cnt_q - 4'd1;
					if (div_cnt_q == 4'd1) begin
						if (!div_sel_q) begin
							needed_q <= div_res;
							if (kind_q == bba_pkg::KIND_SHRINK) begin
								// second pass: blocks of the existing reservation
								div_num_q <= rlen_q;
								div_rem_q <= '0;
								div_quo_q <= '0;
								div_cnt_q <= 4'(LEN_W);
								div_sel_q <= 1'b1;
							end else begin
								state_q <= S_PROD;
							end
						end else begin
							orig_q  <= div_res;
							state_q <= S_PROD;
						end
					end
				end

				S_PROD: begin
					prod_q  <= mul_p;
					state_q <= S_DECIDE;
				end

				S_DECIDE: begin
					// default: plain counting sweep over the managed blocks
					sw_i_q   <= '0;
					sw_end_q <= n_blk;
					lo_q     <= '0;
					hi_q     <= '0;
					wval_q   <= 1'b0;
					cnt_q    <= '0;
					state_q  <= S_SWEEP;
					unique case (kind_q)
						bba_pkg::KIND_ALLOC: begin
							if (vlen_zero) begin
								status_q <= bba_pkg::ST_ZERO;
							end else begin
								run_q   <= '0;
								state_q <= S_SCAN;
							end
						end
						bba_pkg::KIND_SHRINK: begin
							if (vlen_zero) begin
								status_q <= bba_pkg::ST_ZERO;
							end else if (prod_q < PROD_W'(vlen_q)) begin
								status_q <= bba_pkg::ST_TOO_LONG;
							end else begin
								// clear the tail; sweep range keeps it inside n
								lo_q     <= EXT_W'(sblk_q) + EXT_W'(needed_q);
								hi_q     <= EXT_W'(sblk_q) + EXT_W'(orig_q);
								placed_q <= 1'b1;
								idx_q    <= IDX_W'(sblk_q);
							end
						end
						bba_pkg::KIND_QUERY: begin
						end
						bba_pkg::KIND_CBEGIN: begin
							sw_end_q <= CW'(MAX_BLOCKS);
							hi_q     <= EXT_W'(MAX_BLOCKS);
							pp_q     <= '0;
						end
						bba_pkg::KIND_PLACE: begin
							if (vlen_zero) begin
								status_q <= bba_pkg::ST_ZERO;
							end else if (pp_end > EXT_W'(n_blk)) begin
								status_q <= bba_pkg::ST_OVERFLOW;
							end else begin
								lo_q     <= EXT_W'(pp_q);
								hi_q     <= pp_end;
								wval_q   <= 1'b1;
								placed_q <= 1'b1;
								idx_q    <= IDX_W'(pp_q);
								pp_q     <= CW'(pp_end);
							end
						end
						default: begin
						end
					endcase
				end

				S_SCAN: begin
					if (rd_v_s1) begin
						cnt_q <= cnt_q + CW'(rd_data_s1);
						run_q <= rd_data_s1 ? '0 : CW'(run_inc);
						if (hit) begin
							placed_q <= 1'b1;
							idx_q    <= hit_idx;
						end
					end
					if (!issue && !rd_v_s1) begin
						if (placed_q) begin
							// mark the run; count continues from the used total
							sw_i_q   <= CW'(idx_q);
							sw_end_q <= CW'(EXT_W'(idx_q) + EXT_W'(needed_q));
							lo_q     <= EXT_W'(idx_q);
							hi_q     <= EXT_W'(idx_q) + EXT_W'(needed_q);
							wval_q   <= 1'b1;
							state_q  <= S_SWEEP;
						end else begin
							status_q <= frag ? bba_pkg::ST_FRAG : bba_pkg::ST_FULL;
							state_q  <= S_MUL;
						end
					end
				end

				S_SWEEP: begin
					if (rd_v_s1) begin
						cnt_q <= cnt_q + CW'(reg_s1 ? wval_q : rd_data_s1);
					end
					if (!issue && !rd_v_s1) begin
						if (init_q) begin
							init_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end

				S_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_DONE;
				end

				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						res_status_q <= status_q;
						res_index_q  <= idx_q[bba_pkg::BI_W-1:0];
						res_offset_q <= prod_q[bba_pkg::OFF_W-1:0];
						res_needed_q <= (needed_q > LEN_W'(bba_pkg::SAT_MAX)) ?
							bba_pkg::SAT_MAX : needed_q[SAT_W-1:0];
						res_occ_q    <= (EXT_W'(cnt_q) > EXT_W'(bba_pkg::SAT_MAX)) ?
							bba_pkg::SAT_MAX : SAT_W'(cnt_q);
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = res_status_q;
	assign block_index    = res_index_q;
	assign byte_offset    = res_offset_q;
	assign blocks_needed  = res_needed_q;
	assign occupied_count = res_occ_q;

	`BBA_ASSERT_HOLDS(a_we_only_in_sweep, clk, arst_n, mem_we, state_q == S_SWEEP,
		"map written outside a sweep")
	`BBA_ASSERT_HOLDS(a_addr_in_map, clk, arst_n, issue, sw_i_q < CW'(MAX_BLOCKS),
		"map access beyond MAX_BLOCKS")
	`BBA_ASSERT_HOLDS(a_count_bound, clk, arst_n, state_q == S_DONE,
		EXT_W'(cnt_q) <= EXT_W'(MAX_BLOCKS), "used count exceeds map size")
	`BBA_ASSERT_NEXT(a_stall_holds_result, clk, arst_n,
		state_q == S_DONE && out_valid_q && !out_ready,
		state_q == S_DONE && out_valid_q, "pending result overwritten")
	`BBA_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_valid && in_ready,
		state_q != S_IDLE, "accepted transaction did not start")

endmodule

FILE: bench/bitmap_block_allocator_tb.sv
// Self-checking testbench for the bitmap block allocator: directed table, then random phases.
module bitmap_block_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bba_pkg::*;

	localparam int MAX_BLOCKS      = MAX_BLOCKS_DEF;
	// watchdog limit for the whole run
	localparam int CYCLE_LIMIT     = 4_000_000;
	localparam int HOLD_CYCLES     = 3000;  // long receiver hold-off, fills the block
	localparam int TAIL_CYCLES     = 600;   // idle tail after draining
	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int NUM_ROWS        = 33;
	localparam int LIVE_MAX        = 48;

	// kinds the block decodes as no-ops
	localparam logic [2:0] KIND_SPARE_5 = 3'd5;
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	typedef struct packed {
		status_t              st;
		logic [BI_W-1:0]      idx;
		logic [OFF_W-1:0]     off;
		logic [SAT_W-1:0]     need;
		logic [SAT_W-1:0]     used;
	} alloc_result_t;

	// one row of the directed table: either a register write or a request
	typedef struct packed {
		logic                 is_cfg;
		logic                 sel;
		logic [CFG_W-1:0]     val;
		logic [2:0]           k;
		logic [LEN_W-1:0]     vl;
		logic [LEN_W-1:0]     rl;
		logic [SB_W-1:0]      sb;
		logic                 typed;
		alloc_result_t        res;
	} dir_row_t;

	// a reservation the random part may later shrink
	typedef struct packed {
		logic [SB_W-1:0]      start;
		logic [LEN_W-1:0]     len;
	} resv_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = 1'b0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [2:0]           kind = '0;
	logic [LEN_W-1:0]     value_length = '0;
	logic [LEN_W-1:0]     reserved_length = '0;
	logic [SB_W-1:0]      start_block = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [2:0]           status;
	logic [BI_W-1:0]      block_index;
	logic [OFF_W-1:0]     byte_offset;
	logic [SAT_W-1:0]     blocks_needed;
	logic [SAT_W-1:0]     occupied_count;

	bitmap_block_allocator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.value_length   (value_length),
		.reserved_length(reserved_length),
		.start_block    (start_block),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.block_index    (block_index),
		.byte_offset    (byte_offset),
		.blocks_needed  (blocks_needed),
		.occupied_count (occupied_count)
	);

	always #2 clk = ~clk;

	// Allocator model state, mirrors the block's map and registers.
	bit [MAX_BLOCKS-1:0]  occ_map = '0;
	int                   pack_ptr = 0;
	logic [BS_W-1:0]      model_bs = BS_RESET;
	logic [BIU_W-1:0]     model_biu = BIU_RESET;

	alloc_result_t        pending_results[$];
	int                   fail_count = 0;

	// pacing knobs; the receiver knobs are written with NBAs from the main thread
	int                   gap_pct = 10;
	int                   stall_pct = 10;
	logic                 hold_go = 1'b0;

	function automatic int blocks_for(input int len);
		int bs;
		bs = (model_bs == 0) ? 1 : int'(model_bs);
		return (len + bs - 1) / bs;
	endfunction

	// One allocator request against the model state; returns what the block must answer.
	function automatic alloc_result_t allocator_step(input logic [2:0] k,
			input logic [LEN_W-1:0] vl, input logic [LEN_W-1:0] rl,
			input logic [SB_W-1:0] sb);
		alloc_result_t r;
		int n, bs, needed, idx, run, freec, orig, used, i, off_full, sbi;
		bit placed;
		n = (model_biu < MAX_BLOCKS) ? int'(model_biu) : MAX_BLOCKS;
		bs = (model_bs == 0) ? 1 : int'(model_bs);
		sbi = int'(sb);
		needed = 0;
		idx = 0;
		placed = 0;
		r.st = ST_OK;
		if (k == KIND_ALLOC || k == KIND_SHRINK || k == KIND_PLACE) begin
			needed = blocks_for(int'(vl));
			if (vl == 0)
				r.st = ST_ZERO;
		end
		if (k == KIND_ALLOC && r.st == ST_OK) begin
			// first fit: lowest run of free blocks long enough
			run = 0;
			freec = 0;
			for (i = 0; i < n; i++) begin
				if (occ_map[i]) begin
					run = 0;
				end else begin
					run++;
					freec++;
					if (!placed && run == needed) begin
						idx = i + 1 - needed;
						placed = 1;
					end
				end
			end
			if (placed) begin
				for (i = 0; i < needed; i++)
					occ_map[idx + i] = 1'b1;
			end else begin
				r.st = (freec >= needed) ? ST_FRAG : ST_FULL;
			end
		end else if (k == KIND_SHRINK && r.st == ST_OK) begin
			orig = blocks_for(int'(rl));
			if (orig * bs < int'(vl)) begin
				r.st = ST_TOO_LONG;
			end else begin
				// free the tail, never past the managed range
				for (i = sbi + needed; i < sbi + orig; i++)
					if (i < n)
						occ_map[i] = 1'b0;
				idx = sbi;
				placed = 1;
			end
		end else if (k == KIND_CBEGIN) begin
			occ_map = '0;
			pack_ptr = 0;
		end else if (k == KIND_PLACE && r.st == ST_OK) begin
			if (pack_ptr + needed > n) begin
				r.st = ST_OVERFLOW;
			end else begin
				for (i = 0; i < needed; i++)
					occ_map[pack_ptr + i] = 1'b1;
				idx = pack_ptr;
				pack_ptr += needed;
				placed = 1;
			end
		end
		used = 0;
		for (i = 0; i < n; i++)
			used += occ_map[i] ? 1 : 0;
		off_full = idx * bs;
		r.idx = placed ? idx[BI_W-1:0] : '0;
		r.off = placed ? off_full[OFF_W-1:0] : '0;
		r.need = (needed > 511) ? SAT_MAX : needed[SAT_W-1:0];
		r.used = (used > 511) ? SAT_MAX : used[SAT_W-1:0];
		return r;
	endfunction

	// Offer one request, wait for its transaction, then log the expectation.
	// Valid stays high on return so back-to-back requests need no second assignment.
	task automatic send_item(input logic [2:0] k, input logic [LEN_W-1:0] vl,
			input logic [LEN_W-1:0] rl, input logic [SB_W-1:0] sb,
			input logic typed, input alloc_result_t typed_res,
			output alloc_result_t pred);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value_length <= vl;
		reserved_length <= rl;
		start_block <= sb;
		do @(posedge clk); while (!in_ready);
		pred = allocator_step(k, vl, rl, sb);
		pending_results.push_back(typed ? typed_res : pred);
	endtask

	// Block is idle once every result is back (every request gives exactly one).
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (sel == CFG_BLOCK_SIZE)
			model_bs = val[BS_W-1:0];
		else
			model_biu = val[BIU_W-1:0];
	endtask

	// Receiver: random stall bursts, plus one long hold-off.
	int hold_left = 0;
	int stall_left = 0;
	logic hold_done = 1'b0;
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result checker: every result transaction against the oldest expectation.
	always @(posedge clk) begin : result_check
		alloc_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result transaction: st=%0d idx=%0d off=%0d need=%0d used=%0d",
						status, block_index, byte_offset, blocks_needed, occupied_count);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (status != e.st || block_index != e.idx || byte_offset != e.off ||
						blocks_needed != e.need || occupied_count != e.used) begin
					if (fail_count < 10)
						$display("mismatch: exp st=%0d idx=%0d off=%0d need=%0d used=%0d / got st=%0d idx=%0d off=%0d need=%0d used=%0d",
							e.st, e.idx, e.off, e.need, e.used,
							status, block_index, byte_offset, blocks_needed, occupied_count);
					fail_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned wd_cycles;
		for (wd_cycles = 0; wd_cycles < CYCLE_LIMIT; wd_cycles++)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// Directed table. Typed expectations only where the answer is obvious;
	// the rest are checked against the model.
	dir_row_t dir_table [NUM_ROWS] = '{
		// fresh map, reset registers (16-byte blocks, 256 managed)
		'{0, 0, 0, KIND_QUERY,   0,    0,    0,   1, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_ALLOC,   0,    0,    0,   1, '{ST_ZERO,     0, 0, 0,   0}},
		'{0, 0, 0, KIND_SHRINK,  0,    100,  5,   1, '{ST_ZERO,     0, 0, 0,   0}},
		'{0, 0, 0, KIND_PLACE,   0,    0,    0,   1, '{ST_ZERO,     0, 0, 0,   0}},
		// longest value fills every block, then nothing fits
		'{0, 0, 0, KIND_ALLOC,   4095, 0,    0,   1, '{ST_OK,       0, 0, 256, 256}},
		'{0, 0, 0, KIND_ALLOC,   1,    0,    0,   1, '{ST_FULL,     0, 0, 1,   256}},
		'{0, 0, 0, KIND_SHRINK,  1,    4095, 0,   1, '{ST_OK,       0, 0, 1,   1}},
		'{0, 0, 0, KIND_SHRINK,  17,   16,   0,   1, '{ST_TOO_LONG, 0, 0, 2,   1}},
		'{0, 0, 0, KIND_ALLOC,   32,   0,    0,   0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_ALLOC,   16,   0,    0,   0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_SHRINK,  16,   32,   1,   0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_ALLOC,   48,   0,    0,   0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_SPARE_5, 4095, 4095, 255, 0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_SPARE_6, 2048, 1,    128, 0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_SPARE_7, 0,    0,    0,   0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_CBEGIN,  4095, 4095, 255, 1, '{ST_OK,       0, 0, 0,   0}},
		// four blocks: pack, overflow, punch holes, fragmented
		'{1, CFG_BLOCKS_IN_USE, 4, KIND_QUERY, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0}},
		'{0, 0, 0, KIND_PLACE,   64,   0,    0,   0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_PLACE,   1,    0,    0,   1, '{ST_OVERFLOW, 0, 0, 1,   4}},
		'{0, 0, 0, KIND_SHRINK,  16,   32,   0,   0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_SHRINK,  16,   32,   2,   0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_ALLOC,   32,   0,    0,   0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_SHRINK,  16,   4095, 3,   0, '{ST_OK,       0, 0, 0,   0}},
		// lowered range leaves stale marks outside
		'{1, CFG_BLOCKS_IN_USE, 2, KIND_QUERY, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0}},
		'{0, 0, 0, KIND_QUERY,   0,    0,    0,   0, '{ST_OK,       0, 0, 0,   0}},
		'{1, CFG_BLOCKS_IN_USE, 0, KIND_QUERY, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0}},
		'{0, 0, 0, KIND_ALLOC,   1,    0,    0,   1, '{ST_FULL,     0, 0, 1,   0}},
		// block size zero acts as one byte
		'{1, CFG_BLOCK_SIZE,    0,   KIND_QUERY, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0}},
		'{1, CFG_BLOCKS_IN_USE, 256, KIND_QUERY, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0}},
		'{0, 0, 0, KIND_ALLOC,   3,    0,    0,   0, '{ST_OK,       0, 0, 0,   0}},
		'{1, CFG_BLOCK_SIZE,    2047, KIND_QUERY, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0}},
		'{0, 0, 0, KIND_ALLOC,   4095, 0,    0,   0, '{ST_OK,       0, 0, 0,   0}},
		'{0, 0, 0, KIND_SHRINK,  4095, 4095, 255, 0, '{ST_OK,       0, 0, 0,   0}}
	};

	// per-phase registers; negative means pick at random
	int phase_bs  [NUM_PHASES] = '{16,  1, 1024, 2047, 0, 7, -1,   3, 64,  -1,  2,  16};
	int phase_biu [NUM_PHASES] = '{256, 8, 16,   32,   4, 1, -1, 511,  0, 256, 40, 128};

	initial begin : stimulus
		alloc_result_t pred, no_res;
		resv_t live_resv[$];
		resv_t rv;
		logic [2:0] k;
		logic [LEN_W-1:0] vl, rl;
		logic [SB_W-1:0] sb;
		int p, i, r, w, j, n_cur, bsz, maxnb, nb, cap, bs_v, biu_v, last_used, hi;
		bit from_live;
		no_res = '0;
		last_used = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < NUM_ROWS; i++) begin
			if (dir_table[i].is_cfg) begin
				wait_idle();
				write_reg(dir_table[i].sel, dir_table[i].val);
			end else begin
				send_item(dir_table[i].k, dir_table[i].vl, dir_table[i].rl, dir_table[i].sb,
					dir_table[i].typed, dir_table[i].res, pred);
			end
		end

		for (p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			bs_v = (phase_bs[p] < 0) ? int'($urandom_range(1, 1024)) : phase_bs[p];
			biu_v = (phase_biu[p] < 0) ? int'($urandom_range(2, 64)) : phase_biu[p];
			write_reg(CFG_BLOCK_SIZE, CFG_W'(bs_v));
			write_reg(CFG_BLOCKS_IN_USE, CFG_W'(biu_v));
			if (p == NUM_PHASES - 1) begin
				// final stretch runs flat out on both sides
				gap_pct = 0;
				stall_pct <= 0;
			end else begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 35;
				endcase
				stall_pct <= (gap_pct == 0) ? 35 : int'($urandom_range(0, 1)) * 10;
			end
			n_cur = (model_biu < MAX_BLOCKS) ? int'(model_biu) : MAX_BLOCKS;
			bsz = (model_bs == 0) ? 1 : int'(model_bs);
			maxnb = n_cur / 4;
			if (maxnb < 1)
				maxnb = 1;
			if (maxnb > 8)
				maxnb = 8;

			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == 1 && i == 40)
					hold_go <= 1'b1;
				from_live = 0;
				j = 0;
				rl = LEN_W'($urandom_range(0, 4095));
				sb = SB_W'($urandom_range(0, 255));
				// small sizes mostly, now and then anything up to the field limit
				nb = $urandom_range(1, maxnb);
				hi = (nb - 1) * bsz + int'($urandom_range(1, bsz));
				if (hi > 4095 || $urandom_range(0, 9) == 0)
					hi = $urandom_range(1, 4095);
				vl = LEN_W'(hi);
				r = $urandom_range(0, 99);
				if (r < 30) begin
					// noise: every field, every kind
					k = 3'($urandom_range(0, 7));
					vl = LEN_W'($urandom_range(0, 4095));
				end else begin
					w = $urandom_range(0, 99);
					if (last_used * 4 > n_cur * 3 && w < 40)
						k = KIND_CBEGIN;
					else if (w < 35 || (w < 65 && live_resv.size() == 0))
						k = KIND_ALLOC;
					else if (w < 65)
						k = KIND_SHRINK;
					else if (w < 75)
						k = KIND_QUERY;
					else if (w < 80)
						k = KIND_CBEGIN;
					else
						k = KIND_PLACE;
					if (k == KIND_SHRINK) begin
						// shrink a reservation handed out earlier
						j = $urandom_range(0, live_resv.size() - 1);
						rv = live_resv[j];
						from_live = 1;
						rl = rv.len;
						sb = rv.start;
						cap = blocks_for(int'(rv.len)) * bsz;
						if (cap < 4095 && $urandom_range(0, 9) == 0) begin
							hi = cap + bsz;
							if (hi > 4095)
								hi = 4095;
							vl = LEN_W'($urandom_range(cap + 1, hi));
						end else begin
							vl = LEN_W'($urandom_range(1, int'(rv.len)));
						end
					end
				end
				send_item(k, vl, rl, sb, 1'b0, no_res, pred);
				last_used = int'(pred.used);
				if (k == KIND_CBEGIN) begin
					live_resv.delete();
				end else if ((k == KIND_ALLOC || k == KIND_PLACE) && pred.st == ST_OK) begin
					rv.start = pred.idx;
					rv.len = vl;
					live_resv.push_back(rv);
					if (live_resv.size() > LIVE_MAX)
						void'(live_resv.pop_front());
				end else if (from_live && pred.st == ST_OK) begin
					live_resv[j].len = vl;
				end
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
